FILE: hw/rtl/rfid_pkg.sv
package rfid_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] tag;
      logic [7:0]  version;
   } rsp_type;

   // Classified beat handed from the front to the back.
   typedef struct packed {
      logic       tick;
      logic [3:0] nibble;
      logic       hex_ok;
      logic       is_head;
      logic       is_tail;
   } entry_type;

   localparam logic       KIND_BYTE = 1'b0;
   localparam logic       KIND_TICK = 1'b1;

   localparam logic       CSR_ENABLE  = 1'b0;
   localparam logic       CSR_TIMEOUT = 1'b1;

   localparam logic [2:0] STATUS_ACCEPTED  = 3'd0;
   localparam logic [2:0] STATUS_FRAMING   = 3'd1;
   localparam logic [2:0] STATUS_BAD_HEX   = 3'd2;
   localparam logic [2:0] STATUS_CHECKSUM  = 3'd3;
   localparam logic [2:0] STATUS_ZERO_TAG  = 3'd4;
   localparam logic [2:0] STATUS_DUPLICATE = 3'd5;

   localparam logic [7:0] HEAD_BYTE = 8'h02;
   localparam logic [7:0] TAIL_BYTE = 8'h03;

   localparam logic [3:0] POS_HEAD         = 4'd0;
   localparam logic [3:0] POS_VERSION_LAST = 4'd2;
   localparam logic [3:0] POS_TAG_LAST     = 4'd10;
   localparam logic [3:0] POS_TAIL         = 4'd13;

   localparam logic [16:0] ELAPSED_MAX     = 17'h1FFFF;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

endpackage

FILE: hw/rtl/rfid_ascii_frame_decoder.sv
// A frame's result is written to the rsp register once its tail byte has passed through the queue to the back end.
// Throughput: one beat per cycle; the back end takes one queued beat each cycle
// and stalls only while a result waits on rsp_stall.
// Bytes and ticks pass in order through a QUEUE_DEPTH-entry queue.
// Reset clears the frame position, tag history, time counter and queue; enable
// resets to 0 and repeat_timeout_ms to 1000.
module rfid_ascii_frame_decoder
   import rfid_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic        enable_ff, enable_in;
   logic [15:0] timeout_ff, timeout_in;
   logic        queue_full;
   logic        push;
   entry_type   push_data;
   logic        pop;
   logic        head_valid;
   entry_type   head_data;

   always_comb begin
      enable_in  = enable_ff;
      timeout_in = timeout_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ENABLE:  enable_in  = csr_wdata[0];
            CSR_TIMEOUT: timeout_in = csr_wdata;
            default:     enable_in  = enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         enable_ff  <= enable_in;
         timeout_ff <= timeout_in;
      end
   end

   rfid_front u_front (
      .enable     (enable_ff),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push       (push),
      .push_data  (push_data)
   );

   rfid_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   rfid_back u_back (
      .clock             (clock),
      .reset             (reset),
      .repeat_timeout_ms (timeout_ff),
      .head_valid        (head_valid),
      .head_data         (head_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data)
   );

endmodule

FILE: hw/rtl/rfid_queue.sv
module rfid_queue
   import rfid_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/rfid_front.sv
module rfid_front
   import rfid_pkg::*;
(
   input  logic      enable,
   input  logic      req_valid,
   input  req_type   req_data,
   input  logic      queue_full,
   output logic      req_stall,
   output logic      push,
   output entry_type push_data
);

   logic [7:0] b;

   assign b         = req_data.byte_value;
   assign req_stall = queue_full;

   // Bytes seen while disabled are taken and dropped; ticks always go through.
   assign push = req_valid && !queue_full &&
                 ((req_data.kind == KIND_TICK) || enable);

   always_comb begin
      push_data.tick    = (req_data.kind == KIND_TICK);
      push_data.is_head = (b == HEAD_BYTE);
      push_data.is_tail = (b == TAIL_BYTE);
      push_data.hex_ok  = 1'b1;
      push_data.nibble  = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         push_data.nibble = b[3:0];
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         push_data.nibble = b[3:0] + 4'd9;
      end else begin
         push_data.hex_ok = 1'b0;
      end
   end

endmodule

FILE: hw/rtl/rfid_back.sv
module rfid_back
   import rfid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] repeat_timeout_ms,
   input  logic        head_valid,
   input  entry_type   head_data,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  ver_ff, ver_in;
   logic [31:0] tag_ff, tag_in;
   logic [7:0]  csum_ff, csum_in;
   logic [1:0]  flags_ff, flags_in;
   logic [31:0] last_ff, last_in;
   logic [16:0] elapsed_ff, elapsed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        is_byte;
   logic [7:0]  sum;
   logic        expired;
   logic [31:0] last_eff;
   logic [2:0]  status;

   assign pop     = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign is_byte = pop && !head_data.tick;

   always_comb begin
      ver_in   = ver_ff;
      tag_in   = tag_ff;
      csum_in  = csum_ff;
      flags_in = flags_ff;
      if (is_byte) begin
         if (pos_ff == POS_HEAD) begin
            ver_in   = '0;
            tag_in   = '0;
            csum_in  = '0;
            flags_in = {1'b0, !head_data.is_head};
         end else if (pos_ff == POS_TAIL) begin
            flags_in[0] = flags_ff[0] | !head_data.is_tail;
         end else begin
            flags_in[1] = flags_ff[1] | !head_data.hex_ok;
            if (pos_ff <= POS_VERSION_LAST) begin
               ver_in = {ver_ff[3:0], head_data.nibble};
            end else if (pos_ff <= POS_TAG_LAST) begin
               tag_in = {tag_ff[27:0], head_data.nibble};
            end else begin
               csum_in = {csum_ff[3:0], head_data.nibble};
            end
         end
      end
   end

   assign sum = csum_in ^ ver_in ^ tag_in[7:0] ^ tag_in[15:8] ^ tag_in[23:16] ^ tag_in[31:24];
   assign expired  = (elapsed_ff > {1'b0, repeat_timeout_ms});
   assign last_eff = expired ? '0 : last_ff;

   always_comb begin
      priority if (flags_in[0]) begin
         status = STATUS_FRAMING;
      end else if (flags_in[1]) begin
         status = STATUS_BAD_HEX;
      end else if (sum != '0) begin
         status = STATUS_CHECKSUM;
      end else if (tag_in == '0) begin
         status = STATUS_ZERO_TAG;
      end else if (tag_in == last_eff) begin
         status = STATUS_DUPLICATE;
      end else begin
         status = STATUS_ACCEPTED;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      last_in      = last_ff;
      elapsed_in   = elapsed_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (pop && head_data.tick) begin
         if (elapsed_ff != ELAPSED_MAX) begin
            elapsed_in = elapsed_ff + 1'b1;
         end
      end else if (is_byte) begin
         if (pos_ff == POS_TAIL) begin
            pos_in              = POS_HEAD;
            rsp_valid_in        = 1'b1;
            rsp_data_in.status  = status;
            rsp_data_in.tag     = tag_in;
            rsp_data_in.version = ver_in;
            if (status == STATUS_ACCEPTED) begin
               last_in    = tag_in;
               elapsed_in = '0;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         ver_ff       <= '0;
         tag_ff       <= '0;
         csum_ff      <= '0;
         flags_ff     <= '0;
         last_ff      <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         ver_ff       <= ver_in;
         tag_ff       <= tag_in;
         csum_ff      <= csum_in;
         flags_ff     <= flags_in;
         last_ff      <= last_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/rfid_checker.sv
module rfid_checker
   import rfid_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rsp_type     rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= STATUS_DUPLICATE)
      else $error("status code out of range");

   a_accept_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_ACCEPTED ||
                    rsp_data.status == STATUS_DUPLICATE) |-> rsp_data.tag != '0)
      else $error("zero tag accepted or reported as duplicate");

endmodule

bind rfid_ascii_frame_decoder rfid_checker u_checker (.*);
